// ===== rtl/sorted_hash_bucket_search_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted hash bucket search: assertion macros
// Clocked assertion shorthands for the bucket search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_HASH_BUCKET_SEARCH_MACROS_SVH
`define SORTED_HASH_BUCKET_SEARCH_MACROS_SVH

// General property on the block clock, off during reset.
`define SHBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication on the block clock, off during reset.
`define SHBS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/shbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted hash bucket search: package
// Operation and status codes, sequencer states, port layout and defaults.
// ----------------------------------------------------------------------------
package shbs_pkg;

   localparam int DEFAULT_BUCKET_DEPTH = 64;
   localparam int DEFAULT_HASH_BITS    = 32;

   // Request layout
   localparam int REQ_HASH_W  = 32;
   localparam int REQ_RANGE_W = 6;
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = 2;
   localparam int REQ_LOW_LSB  = REQ_HASH_W;
   localparam int REQ_HIGH_LSB = REQ_HASH_W + REQ_RANGE_W;

   // Response layout
   localparam int RSP_POS_W   = 6;
   localparam int RSP_STAT_W  = 2;
   localparam int RSP_TOTAL_W = 7;
   localparam int RSP_DATA_W  = 16;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SORT   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [RSP_STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT_OUTER,
      S_SORT_LOAD,
      S_SORT_CMP,
      S_SRCH_START,
      S_SRCH_MID,
      S_SRCH_CMP,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/sorted_hash_bucket_search.sv =====
// ----------------------------------------------------------------------------
// Sorted hash bucket search
// Hash bucket with clear, append, in-place insertion sort and bisection search.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_tready is high only while the sequencer
// is idle, and a finished response waits in the output register so the next
// request may be taken meanwhile. A request whose response finds that register
// still full waits in its finishing state until the held response is taken. A
// search makes at most 7 probes at the default depth, each probe being the
// registered read of the single store read port followed by the shared compare.
// A sort of N residents shifts at most N*(N-1)/2 entries, with at most one store
// read and one store write per cycle. The store holds nothing meaningful until
// written; reads whose data is used stay within the resident count.
// ----------------------------------------------------------------------------
module sorted_hash_bucket_search
   import shbs_pkg::*;
#(
   parameter int BUCKET_DEPTH = DEFAULT_BUCKET_DEPTH,
   parameter int HASH_BITS    = DEFAULT_HASH_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: hash_value[31:0], range_low[37:32], range_high[43:38], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // request: op[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // response: found[0], position[6:1], status[8:7], resident_total[15:9]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

`include "sorted_hash_bucket_search_macros.svh"

   localparam int IDX_W = $clog2(BUCKET_DEPTH);
   localparam int CNT_W = $clog2(BUCKET_DEPTH + 1);
   localparam int SW    = (CNT_W > RSP_TOTAL_W) ? CNT_W : RSP_TOTAL_W;

   // request fields
   op_type                 req_op;
   logic [REQ_HASH_W-1:0]  req_hash;
   logic [REQ_RANGE_W-1:0] req_low;
   logic [REQ_RANGE_W-1:0] req_high;
   logic                   req_xfer;

   assign req_op   = op_type'(req_tuser);
   assign req_hash = req_tdata[REQ_HASH_W-1:0];
   assign req_low  = req_tdata[REQ_LOW_LSB +: REQ_RANGE_W];
   assign req_high = req_tdata[REQ_HIGH_LSB +: REQ_RANGE_W];
   assign req_xfer = req_tvalid && req_tready;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CNT_W-1:0]     sort_i_ff, sort_i_in;
   logic [IDX_W-1:0]     sort_j_ff, sort_j_in;
   logic [HASH_BITS-1:0] key_ff, key_in;
   logic [SW-1:0]        lo_ff, lo_in;
   logic [SW-1:0]        hi_ff, hi_in;
   logic [SW-1:0]        mid_ff, mid_in;
   logic                 found_ff, found_in;
   status_type           status_ff, status_in;

   // response payload
   logic                   rsp_found_ff, rsp_found_in;
   logic [RSP_POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [RSP_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // store
   logic [HASH_BITS-1:0] store_ff [BUCKET_DEPTH];
   logic [HASH_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [HASH_BITS-1:0] wr_data;

   // shared compare unit
   logic key_lt;
   logic key_eq;

   assign key_lt = key_ff < rd_data_ff;
   assign key_eq = key_ff == rd_data_ff;

   logic [SW-1:0] count_wide;
   logic [SW-1:0] last_idx;
   logic [SW-1:0] mid_calc;
   logic          rsp_free;

   assign count_wide = SW'(count_ff);
   assign last_idx   = count_wide - SW'(1);
   assign mid_calc   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sort_i_ff     <= sort_i_in;
      sort_j_ff     <= sort_j_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      sort_i_in     = sort_i_ff;
      sort_j_in     = sort_j_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = sort_j_ff;
      wr_data       = key_ff;
      req_tready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               key_in    = HASH_BITS'(req_hash);
               lo_in     = SW'(req_low);
               hi_in     = SW'(req_high);
               mid_in    = '0;
               found_in  = 1'b0;
               status_in = ST_OK;
               case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_FINISH;
                  end
                  OP_APPEND: begin
                     if (count_ff == CNT_W'(BUCKET_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = HASH_BITS'(req_hash);
                        count_in = count_ff + CNT_W'(1);
                     end
                     state_in = S_FINISH;
                  end
                  OP_SORT: begin
                     sort_i_in = CNT_W'(1);
                     state_in  = S_SORT_OUTER;
                  end
                  OP_SEARCH: begin
                     state_in = S_SRCH_START;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_SORT_OUTER: begin
            if (sort_i_ff < count_ff) begin
               rd_addr  = sort_i_ff[IDX_W-1:0];
               state_in = S_SORT_LOAD;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_SORT_LOAD: begin
            key_in    = rd_data_ff;
            sort_j_in = sort_i_ff[IDX_W-1:0];
            rd_addr   = sort_i_ff[IDX_W-1:0] - IDX_W'(1);
            state_in  = S_SORT_CMP;
         end

         // rd_data_ff holds the entry just below sort_j_ff
         S_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = sort_j_ff;
            if (sort_j_ff == '0 || !key_lt) begin
               wr_data   = key_ff;
               sort_i_in = sort_i_ff + CNT_W'(1);
               state_in  = S_SORT_OUTER;
            end else begin
               wr_data   = rd_data_ff;
               sort_j_in = sort_j_ff - IDX_W'(1);
               rd_addr   = sort_j_ff - IDX_W'(2);
            end
         end

         S_SRCH_START: begin
            if (count_ff == '0) begin
               status_in = ST_MISS;
               state_in  = S_FINISH;
            end else begin
               if (hi_ff > last_idx) begin
                  hi_in = last_idx;
               end
               state_in = S_SRCH_MID;
            end
         end

         S_SRCH_MID: begin
            if (lo_ff > hi_ff) begin
               status_in = ST_MISS;
               state_in  = S_FINISH;
            end else begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[IDX_W-1:0];
               state_in = S_SRCH_CMP;
            end
         end

         S_SRCH_CMP: begin
            if (key_eq) begin
               found_in = 1'b1;
               state_in = S_FINISH;
            end else if (key_lt) begin
               if (mid_ff == '0) begin
                  status_in = ST_MISS;
                  state_in  = S_FINISH;
               end else begin
                  hi_in    = mid_ff - SW'(1);
                  state_in = S_SRCH_MID;
               end
            end else begin
               lo_in    = mid_ff + SW'(1);
               state_in = S_SRCH_MID;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_pos_in    = found_ff ? mid_ff[RSP_POS_W-1:0] : '0;
               rsp_status_in = status_ff;
               rsp_total_in  = count_wide[RSP_TOTAL_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_status_ff, rsp_pos_ff, rsp_found_ff};

   // checks
   `SHBS_ASSERT(a_clear_empties, (req_xfer && req_op == OP_CLEAR) |=> (count_ff == '0), "clear left residents")
   `SHBS_ASSERT(a_append_counts, (req_xfer && req_op == OP_APPEND && count_ff != CNT_W'(BUCKET_DEPTH)) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "append did not add one resident")
   `SHBS_ASSERT_IMPLY(a_found_ok, rsp_valid_ff && rsp_found_ff, rsp_status_ff == ST_OK, "found with bad status")
   `SHBS_ASSERT_IMPLY(a_full_only_when_full, rsp_valid_ff && rsp_status_ff == ST_FULL, rsp_total_ff == RSP_TOTAL_W'(BUCKET_DEPTH), "full below depth")

endmodule

// ===== tb/sorted_hash_bucket_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted hash bucket search: regression bench
// Drives clear, append, sort and search requests through the request stream.
// Every response is checked against a bucket mirror held in the bench. The
// run covers directed edge cases, a long output hold-off, and random
// clear/fill/sort/search runs under three idling mixes.
// ----------------------------------------------------------------------------
module sorted_hash_bucket_search_tb;
   import shbs_pkg::*;

   localparam int DEPTH       = DEFAULT_BUCKET_DEPTH;
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 640;
   localparam int REQ_PAD_W   = REQ_DATA_W - REQ_HIGH_LSB - REQ_RANGE_W;

   typedef struct {
      logic                   found;
      logic [RSP_POS_W-1:0]   position;
      status_type             status;
      logic [RSP_TOTAL_W-1:0] total;
   } bucket_answer_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   // request: hash_value[31:0], range_low[37:32], range_high[43:38], zero pad
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // request: op[1:0]
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // response: found[0], position[6:1], status[8:7], resident_total[15:9]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // bucket mirror
   logic [REQ_HASH_W-1:0] bucket_entries [DEPTH];
   int                    bucket_count;
   bucket_answer_type     answers_due [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;
   int items_sent;
   int mismatch_count;
   int quiet_cycles;

   sorted_hash_bucket_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------- mirror

   function automatic bit bisect_bucket(logic [REQ_HASH_W-1:0] key, int lo, int hi,
                                        output int pos);
      int mid;
      pos = 0;
      if (bucket_count == 0) return 1'b0;
      if (hi > bucket_count - 1) hi = bucket_count - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (bucket_entries[mid] == key) begin
            pos = mid;
            return 1'b1;
         end
         if (key < bucket_entries[mid]) begin
            // key below entry 0: give up, no wrap
            if (mid == 0) return 1'b0;
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bucket_answer_type predict_bucket_op(op_type op,
                                                           logic [REQ_HASH_W-1:0] hash,
                                                           int lo, int hi);
      bucket_answer_type     ans;
      logic [REQ_HASH_W-1:0] v;
      int                    i;
      int                    j;
      int                    pos;
      ans.found    = 1'b0;
      ans.position = '0;
      ans.status   = ST_OK;
      case (op)
         OP_CLEAR: begin
            bucket_count = 0;
         end
         OP_APPEND: begin
            if (bucket_count >= DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               bucket_entries[bucket_count] = hash;
               bucket_count++;
            end
         end
         OP_SORT: begin
            for (i = 1; i < bucket_count; i++) begin
               v = bucket_entries[i];
               j = i;
               while (j > 0 && bucket_entries[j-1] > v) begin
                  bucket_entries[j] = bucket_entries[j-1];
                  j--;
               end
               bucket_entries[j] = v;
            end
         end
         default: begin
            if (bisect_bucket(hash, lo, hi, pos)) begin
               ans.found    = 1'b1;
               ans.position = RSP_POS_W'(pos);
            end else begin
               ans.status = ST_MISS;
            end
         end
      endcase
      ans.total = RSP_TOTAL_W'(bucket_count);
      return ans;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [REQ_HASH_W-1:0] random_hash();
      int r;
      r = $urandom_range(99);
      if (r < 55) return $urandom;
      if (r < 80) return $urandom_range(0, 31);
      if (r < 90) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      return 32'hFFFF_FFE0 | $urandom_range(0, 31);
   endfunction

   function automatic logic [REQ_HASH_W-1:0] pick_search_key();
      int                    r;
      logic [REQ_HASH_W-1:0] v;
      r = $urandom_range(99);
      if (bucket_count == 0 || r < 20) return $urandom;
      v = bucket_entries[$urandom_range(0, bucket_count - 1)];
      if (r < 30) return v + 1;
      if (r < 40) return v - 1;
      return v;
   endfunction

   function automatic void pick_range(output logic [REQ_RANGE_W-1:0] lo,
                                      output logic [REQ_RANGE_W-1:0] hi);
      int r;
      r  = $urandom_range(99);
      lo = '0;
      hi = 6'd63;
      if (r >= 85) begin
         lo = 6'($urandom);
         hi = 6'($urandom);
      end else if (r >= 75) begin
         lo = 6'($urandom_range(0, (bucket_count > 0) ? bucket_count - 1 : 0));
      end else if (r >= 60) begin
         hi = 6'($urandom);
      end
   endfunction

   task automatic send_bucket_op(op_type op, logic [REQ_HASH_W-1:0] hash,
                                 logic [REQ_RANGE_W-1:0] lo, logic [REQ_RANGE_W-1:0] hi);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, hi, lo, hash};
      do @(posedge clock); while (req_tready !== 1'b1);
      answers_due.push_back(predict_bucket_op(op, hash, lo, hi));
      items_sent++;
   endtask

   task automatic send_search();
      logic [REQ_RANGE_W-1:0] lo;
      logic [REQ_RANGE_W-1:0] hi;
      pick_range(lo, hi);
      send_bucket_op(OP_SEARCH, pick_search_key(), lo, hi);
   endtask

   task automatic drain_bucket();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_empty_bucket();
      send_bucket_op(OP_SEARCH, 32'h0000_0000, 6'd0, 6'd63);
      send_bucket_op(OP_SEARCH, 32'hFFFF_FFFF, 6'd63, 6'd0);
      send_bucket_op(OP_SORT, 32'hFFFF_FFFF, 6'd63, 6'd63);
      send_bucket_op(OP_CLEAR, 32'h0000_0000, 6'd0, 6'd0);
      drain_bucket();
   endtask

   task automatic test_extreme_hashes();
      send_bucket_op(OP_APPEND, 32'hFFFF_FFFF, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'h0000_0000, 6'd63, 6'd63);
      send_bucket_op(OP_APPEND, 32'h8000_0000, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'h7FFF_FFFF, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'h1234_5678, 6'd0, 6'd0);
      // unsorted bisection, then full-width unsigned ordering
      send_bucket_op(OP_SEARCH, 32'h8000_0000, 6'd0, 6'd63);
      send_bucket_op(OP_SORT, 32'h0000_0000, 6'd0, 6'd0);
      send_bucket_op(OP_SEARCH, 32'h0000_0000, 6'd0, 6'd63);
      send_bucket_op(OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 6'd63);
      send_bucket_op(OP_SEARCH, 32'h7FFF_FFFF, 6'd0, 6'd63);
      send_bucket_op(OP_SEARCH, 32'h8000_0000, 6'd0, 6'd63);
      drain_bucket();
   endtask

   task automatic test_search_edges();
      send_bucket_op(OP_CLEAR, 32'h0000_0000, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'd9, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'd5, 6'd0, 6'd0);
      send_bucket_op(OP_SORT, 32'h0000_0000, 6'd0, 6'd0);
      // key below entry 0
      send_bucket_op(OP_SEARCH, 32'd1, 6'd0, 6'd63);
      send_bucket_op(OP_SEARCH, 32'd9, 6'd1, 6'd1);
      // low above high, and range beyond the residents
      send_bucket_op(OP_SEARCH, 32'd5, 6'd1, 6'd0);
      send_bucket_op(OP_SEARCH, 32'd9, 6'd63, 6'd63);
      // single resident sort
      send_bucket_op(OP_CLEAR, 32'h0000_0000, 6'd0, 6'd0);
      send_bucket_op(OP_APPEND, 32'd3, 6'd0, 6'd0);
      send_bucket_op(OP_SORT, 32'h0000_0000, 6'd0, 6'd0);
      send_bucket_op(OP_SEARCH, 32'd3, 6'd0, 6'd63);
      drain_bucket();
   endtask

   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 400;
      send_bucket_op(OP_CLEAR, $urandom, 6'($urandom), 6'($urandom));
      repeat (14) send_bucket_op(OP_APPEND, random_hash(), 6'($urandom), 6'($urandom));
      send_search();
      drain_bucket();
   endtask

   task automatic run_bucket_sequence();
      int r;
      int n;
      int extra;
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 4))
            send_bucket_op(op_type'($urandom_range(0, 3)), $urandom, 6'($urandom), 6'($urandom));
         return;
      end
      r = $urandom_range(99);
      if (r < 65)      n = $urandom_range(1, 12);
      else if (r < 90) n = $urandom_range(13, 63);
      else             n = DEPTH;
      extra = (n == DEPTH) ? $urandom_range(1, 3) : 0;
      send_bucket_op(OP_CLEAR, $urandom, 6'($urandom), 6'($urandom));
      repeat (n + extra) send_bucket_op(OP_APPEND, random_hash(), 6'($urandom), 6'($urandom));
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) send_search();
      if ($urandom_range(99) < 90)
         send_bucket_op(OP_SORT, $urandom, 6'($urandom), 6'($urandom));
      repeat ($urandom_range(3, 8)) send_search();
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 2))
            send_bucket_op(OP_APPEND, random_hash(), 6'($urandom), 6'($urandom));
         repeat (2) send_search();
      end
   endtask

   task automatic test_random_sequences(int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) run_bucket_sequence();
      drain_bucket();
   endtask

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_response
      bucket_answer_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (answers_due.size() == 0) begin
            $error("response transfer with nothing outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[6:1] !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_tdata[6:1]);
               mismatch_count++;
            end
            if (rsp_tdata[8:7] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[8:7]);
               mismatch_count++;
            end
            if (rsp_tdata[15:9] !== want.total) begin
               $error("resident_total: expected %0d, actual %0d", want.total, rsp_tdata[15:9]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sorted_hash_bucket_search regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_bucket();
      test_extreme_hashes();
      test_search_edges();
      test_output_hold_off();

      send_idle_pct = 12;
      recv_idle_pct = 56;
      test_random_sequences(PHASE_ITEMS);
      send_idle_pct = 56;
      recv_idle_pct = 12;
      test_random_sequences(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sequences(PHASE_ITEMS);

      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_hash_bucket_search regression: pass");
      end else begin
         $display("sorted_hash_bucket_search regression: fail");
      end
      $finish;
   end

endmodule
